/* src/assert_macros.svh */
// Assertion macros shared by the checker files.
// Every macro samples on clk and is disabled while rst_n is low.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication.
`define OBB_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Implication with a fixed delay, given by n.
`define OBB_ASSERT_LAT(lbl, ante, cons, n, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> ##(n) (cons)) \
    else $error(msg);

`endif

/* src/obbpq_pkg.sv */
// Shared constants and types for the oriented-box point query block.
// No dependencies; used by obb_point_query_top and obbpq_checker.
package obbpq_pkg;

  localparam int CENTER_REG_W = 63;
  localparam int HALF_REG_W   = 60;
  localparam int BASIS_REG_W  = 48;
  localparam int CFG_DATA_W   = 64;
  localparam int CFG_INDEX_W  = 3;

  // Register stages from accepted point to result strobe.
  localparam int PIPE_DEPTH   = 7;

  typedef enum logic [CFG_INDEX_W-1:0] {
    CFG_CENTER  = 3'd0,
    CFG_HALF    = 3'd1,
    CFG_BASIS_I = 3'd2,
    CFG_BASIS_J = 3'd3,
    CFG_BASIS_K = 3'd4
  } cfg_index_t;

endpackage

/* src/obb_point_query_top.sv */
// Point query against a 3D oriented bounding box: strict inside flag and nearest box point.
// Depends on obbpq_pkg for register widths, register indexes and pipeline depth.
//
//   channel | ports                                        | handshake
//   --------+----------------------------------------------+---------------------------
//   input   | in_point_x, in_point_y, in_point_z           | start high, busy low
//   result  | out_inside_res, out_nearest_x/_y/_z          | out_valid, one cycle, no stall
//   config  | cfg_index, cfg_data                          | cfg_valid and cfg_ready
//
// Seven register stages: offset, nine projection products, projection sums, clamp,
// nine rebuild products, rounded sums, centre add with saturation.
// One point per cycle; a result strobes when its transfer leaves the last stage.
// busy stays low and cfg_ready stays high; nothing in the pipe ever waits.
// Synchronous reset clears valid bits, outputs, centre and extents; axes reset to identity.
module obb_point_query_top #(
  parameter int COORD_WIDTH     = 21,
  parameter int BASIS_FRAC_BITS = 14
) (
  input  logic                                 clk,
  input  logic                                 rst_n,
  input  logic                                 start,
  output logic                                 busy,
  input  logic signed [COORD_WIDTH-1:0]        in_point_x,
  input  logic signed [COORD_WIDTH-1:0]        in_point_y,
  input  logic signed [COORD_WIDTH-1:0]        in_point_z,
  input  logic                                 cfg_valid,
  output logic                                 cfg_ready,
  input  logic [obbpq_pkg::CFG_INDEX_W-1:0]    cfg_index,
  input  logic [obbpq_pkg::CFG_DATA_W-1:0]     cfg_data,
  output logic                                 out_valid,
  output logic                                 out_inside_res,
  output logic signed [COORD_WIDTH-1:0]        out_nearest_x,
  output logic signed [COORD_WIDTH-1:0]        out_nearest_y,
  output logic signed [COORD_WIDTH-1:0]        out_nearest_z
);

  localparam int CW        = COORD_WIDTH;
  localparam int BF        = BASIS_FRAC_BITS;
  localparam int HALF_W    = CW - 1;
  localparam int BASIS_W   = BF + 2;
  localparam int DLT_W     = CW + 1;
  localparam int PROD1_W   = DLT_W + BASIS_W;
  localparam int SUM1_W    = PROD1_W + 2;
  localparam int PROJ_W    = (SUM1_W > 64) ? 64 : SUM1_W;
  localparam int CMP_W     = PROJ_W + 1;
  localparam int HEXT_W    = HALF_W + BF;
  localparam int CLP_W     = HEXT_W + 1;
  localparam int PROD2_W   = BASIS_W + CLP_W;
  localparam int SUM2_W    = PROD2_W + 2;
  localparam int RW        = (SUM2_W > 64) ? 64 : SUM2_W;
  localparam int SHIFT     = 2 * BF;
  localparam int Q_W       = RW - SHIFT;
  localparam int V_W       = ((Q_W > CW) ? Q_W : CW) + 1;
  localparam int CEN_EXT_W = obbpq_pkg::CENTER_REG_W + 3 * CW;
  localparam int HLF_EXT_W = obbpq_pkg::HALF_REG_W + 3 * HALF_W;
  localparam int BAS_EXT_W = obbpq_pkg::BASIS_REG_W + 3 * BASIS_W;
  localparam int DEPTH     = obbpq_pkg::PIPE_DEPTH;

  localparam logic [63:0] BASIS_I_RST = 64'd1 << BF;
  localparam logic [63:0] BASIS_J_RST = BASIS_I_RST << BASIS_W;
  localparam logic [63:0] BASIS_K_RST = BASIS_J_RST << BASIS_W;

  localparam logic [SUM2_W-1:0] ROUND_HALF = SUM2_W'(1) << (SHIFT - 1);
  localparam logic signed [V_W-1:0] SAT_HI =
    {{(V_W - CW + 1){1'b0}}, {(CW - 1){1'b1}}};
  localparam logic signed [V_W-1:0] SAT_LO = ~SAT_HI;

  // ---------------------------------------------------------------- config
  logic [obbpq_pkg::CENTER_REG_W-1:0] center_r;
  logic [obbpq_pkg::HALF_REG_W-1:0]   half_r;
  logic [obbpq_pkg::BASIS_REG_W-1:0]  basis_i_r, basis_j_r, basis_k_r;

  assign cfg_ready = 1'b1;
  assign busy      = 1'b0;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      center_r  <= '0;
      half_r    <= '0;
      basis_i_r <= BASIS_I_RST[obbpq_pkg::BASIS_REG_W-1:0];
      basis_j_r <= BASIS_J_RST[obbpq_pkg::BASIS_REG_W-1:0];
      basis_k_r <= BASIS_K_RST[obbpq_pkg::BASIS_REG_W-1:0];
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        obbpq_pkg::CFG_CENTER:  center_r  <= cfg_data[obbpq_pkg::CENTER_REG_W-1:0];
        obbpq_pkg::CFG_HALF:    half_r    <= cfg_data[obbpq_pkg::HALF_REG_W-1:0];
        obbpq_pkg::CFG_BASIS_I: basis_i_r <= cfg_data[obbpq_pkg::BASIS_REG_W-1:0];
        obbpq_pkg::CFG_BASIS_J: basis_j_r <= cfg_data[obbpq_pkg::BASIS_REG_W-1:0];
        obbpq_pkg::CFG_BASIS_K: basis_k_r <= cfg_data[obbpq_pkg::BASIS_REG_W-1:0];
        default: ;
      endcase
    end
  end

  // Unpack fields; bits past the register read as zero.
  logic [CEN_EXT_W-1:0] cen_ext;
  logic [HLF_EXT_W-1:0] hlf_ext;
  logic [BAS_EXT_W-1:0] bas_ext [3];

  assign cen_ext    = CEN_EXT_W'(center_r);
  assign hlf_ext    = HLF_EXT_W'(half_r);
  assign bas_ext[0] = BAS_EXT_W'(basis_i_r);
  assign bas_ext[1] = BAS_EXT_W'(basis_j_r);
  assign bas_ext[2] = BAS_EXT_W'(basis_k_r);

  logic signed [CW-1:0]      cen  [3];
  logic [HEXT_W-1:0]         hext [3];
  logic signed [BASIS_W-1:0] bas  [3][3];

  for (genvar a = 0; a < 3; a++) begin : g_unpack
    assign cen[a]  = cen_ext[a*CW +: CW];
    assign hext[a] = {hlf_ext[a*HALF_W +: HALF_W], {BF{1'b0}}};
    for (genvar m = 0; m < 3; m++) begin : g_comp
      assign bas[a][m] = bas_ext[a][m*BASIS_W +: BASIS_W];
    end
  end

  // ---------------------------------------------------------------- valid chain
  logic [DEPTH-1:0] vld_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else begin
      vld_r <= {vld_r[DEPTH-2:0], start && !busy};
    end
  end

  assign out_valid = vld_r[DEPTH-1];

  // ---------------------------------------------------------------- stage 1: offset
  logic signed [CW-1:0]    pt [3];
  logic signed [DLT_W-1:0] dlt_nxt [3];
  logic signed [DLT_W-1:0] dlt_r   [3];

  assign pt[0] = in_point_x;
  assign pt[1] = in_point_y;
  assign pt[2] = in_point_z;

  always_comb begin
    for (int m = 0; m < 3; m++) begin
      dlt_nxt[m] = {pt[m][CW-1], pt[m]} - {cen[m][CW-1], cen[m]};
    end
  end

  // ---------------------------------------------------------------- stage 2: products
  logic signed [PROD1_W-1:0] prod1_nxt [3][3];
  logic signed [PROD1_W-1:0] prod1_r   [3][3];

  always_comb begin
    for (int a = 0; a < 3; a++) begin
      for (int m = 0; m < 3; m++) begin
        prod1_nxt[a][m] = PROD1_W'(dlt_r[m]) * PROD1_W'(bas[a][m]);
      end
    end
  end

  // ---------------------------------------------------------------- stage 3: projections
  logic signed [SUM1_W-1:0] sum1 [3];
  logic signed [PROJ_W-1:0] proj_nxt [3];
  logic signed [PROJ_W-1:0] proj_r   [3];

  always_comb begin
    for (int a = 0; a < 3; a++) begin
      sum1[a] = SUM1_W'(prod1_r[a][0]) + SUM1_W'(prod1_r[a][1]) + SUM1_W'(prod1_r[a][2]);
      proj_nxt[a] = sum1[a][PROJ_W-1:0];
    end
  end

  // ---------------------------------------------------------------- stage 4: clamp
  logic signed [CMP_W-1:0] p_ext  [3];
  logic signed [CMP_W-1:0] h_pos  [3];
  logic signed [CMP_W-1:0] h_neg  [3];
  logic signed [CMP_W-1:0] c_sel  [3];
  logic signed [CLP_W-1:0] clp_nxt [3];
  logic signed [CLP_W-1:0] clp_r   [3];
  logic [2:0]              axis_in;
  logic                    in4_nxt;
  logic                    in4_r, in5_r, in6_r;

  always_comb begin
    for (int a = 0; a < 3; a++) begin
      p_ext[a] = CMP_W'(proj_r[a]);
      h_pos[a] = CMP_W'(hext[a]);
      h_neg[a] = -h_pos[a];
      axis_in[a] = (p_ext[a] < h_pos[a]) && (p_ext[a] > h_neg[a]);
      if (p_ext[a] > h_pos[a]) begin
        c_sel[a] = h_pos[a];
      end else if (p_ext[a] < h_neg[a]) begin
        c_sel[a] = h_neg[a];
      end else begin
        c_sel[a] = p_ext[a];
      end
      clp_nxt[a] = c_sel[a][CLP_W-1:0];
    end
    in4_nxt = &axis_in;
  end

  // ---------------------------------------------------------------- stage 5: rebuild products
  logic signed [PROD2_W-1:0] prod2_nxt [3][3];
  logic signed [PROD2_W-1:0] prod2_r   [3][3];

  always_comb begin
    for (int a = 0; a < 3; a++) begin
      for (int m = 0; m < 3; m++) begin
        prod2_nxt[a][m] = PROD2_W'(bas[a][m]) * PROD2_W'(clp_r[a]);
      end
    end
  end

  // ---------------------------------------------------------------- stage 6: round
  logic [SUM2_W-1:0]     sum2 [3];
  logic signed [Q_W-1:0] q_nxt [3];
  logic signed [Q_W-1:0] q_r   [3];

  always_comb begin
    for (int m = 0; m < 3; m++) begin
      sum2[m] = ROUND_HALF + SUM2_W'(prod2_r[0][m]) + SUM2_W'(prod2_r[1][m])
              + SUM2_W'(prod2_r[2][m]);
      // floor shift: keep the upper bits of the wrapped sum
      q_nxt[m] = sum2[m][RW-1:SHIFT];
    end
  end

  // ---------------------------------------------------------------- stage 7: centre, saturate
  logic signed [V_W-1:0] v_sum [3];
  logic signed [V_W-1:0] v_sat [3];
  logic signed [CW-1:0]  near_nxt [3];

  always_comb begin
    for (int m = 0; m < 3; m++) begin
      v_sum[m] = V_W'(cen[m]) + V_W'(q_r[m]);
      if (v_sum[m] > SAT_HI) begin
        v_sat[m] = SAT_HI;
      end else if (v_sum[m] < SAT_LO) begin
        v_sat[m] = SAT_LO;
      end else begin
        v_sat[m] = v_sum[m];
      end
      near_nxt[m] = v_sat[m][CW-1:0];
    end
  end

  // ---------------------------------------------------------------- payload registers
  always_ff @(posedge clk) begin
    dlt_r   <= dlt_nxt;
    prod1_r <= prod1_nxt;
    proj_r  <= proj_nxt;
    clp_r   <= clp_nxt;
    in4_r   <= in4_nxt;
    prod2_r <= prod2_nxt;
    in5_r   <= in4_r;
    q_r     <= q_nxt;
    in6_r   <= in5_r;
  end

  // Hold the result between strobes.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_inside_res <= 1'b0;
      out_nearest_x  <= '0;
      out_nearest_y  <= '0;
      out_nearest_z  <= '0;
    end else if (vld_r[DEPTH-2]) begin
      out_inside_res <= in6_r;
      out_nearest_x  <= near_nxt[0];
      out_nearest_y  <= near_nxt[1];
      out_nearest_z  <= near_nxt[2];
    end
  end

endmodule

/* src/obbpq_checker.sv */
// Port-level checks for obb_point_query_top, attached by bind.
// Depends on obbpq_pkg and assert_macros.svh.
`include "assert_macros.svh"

module obbpq_checker #(
  parameter int COORD_WIDTH = 21
) (
  input logic                              clk,
  input logic                              rst_n,
  input logic                              start,
  input logic                              busy,
  input logic                              out_valid,
  input logic                              out_inside_res,
  input logic signed [COORD_WIDTH-1:0]     out_nearest_x,
  input logic signed [COORD_WIDTH-1:0]     out_nearest_y,
  input logic signed [COORD_WIDTH-1:0]     out_nearest_z
);

  logic                   in_xfer;
  logic [3*COORD_WIDTH:0] res_bus;

  assign in_xfer = start && !busy;
  assign res_bus = {out_inside_res, out_nearest_x, out_nearest_y, out_nearest_z};

  // Every input transfer yields a result strobe after the pipeline depth.
  `OBB_ASSERT_LAT(a_result_follows, in_xfer, out_valid, obbpq_pkg::PIPE_DEPTH, "missing result")

  // No strobe without a matching input transfer.
  `OBB_ASSERT_IMP(a_no_phantom, out_valid, $past(in_xfer, obbpq_pkg::PIPE_DEPTH), "phantom result")

  // Result ports hold between strobes.
  `OBB_ASSERT_IMP(a_idle_hold, !out_valid, $stable(res_bus), "result changed without strobe")

endmodule

bind obb_point_query_top obbpq_checker #(.COORD_WIDTH(COORD_WIDTH)) u_obbpq_checker (
  .clk            (clk),
  .rst_n          (rst_n),
  .start          (start),
  .busy           (busy),
  .out_valid      (out_valid),
  .out_inside_res (out_inside_res),
  .out_nearest_x  (out_nearest_x),
  .out_nearest_y  (out_nearest_y),
  .out_nearest_z  (out_nearest_z)
);

/* sim/tb_obb_point_query_top.sv */
`timescale 1ns / 1ps
// Self-checking bench for obb_point_query_top: queued query points, clocked driver and monitor.
// Depends on obbpq_pkg and the block itself; predicts each answer from a copy of the box.
module tb_obb_point_query_top;

  localparam int COORD_W = 21;
  localparam int FRAC_B = 14;
  localparam int HALF_W = COORD_W - 1;
  localparam int AXIS_W = FRAC_B + 2;
  localparam longint COORD_MAX = (longint'(1) << (COORD_W - 1)) - 1;
  localparam longint COORD_MIN = -(longint'(1) << (COORD_W - 1));
  localparam int CLK_PERIOD = 12;
  localparam int RANDOM_PHASES = 12;
  localparam int PHASE_POINTS = 153;

  typedef struct {
    logic signed [COORD_W-1:0] x;
    logic signed [COORD_W-1:0] y;
    logic signed [COORD_W-1:0] z;
  } query_point_t;

  typedef struct {
    logic in_box;
    logic signed [COORD_W-1:0] x;
    logic signed [COORD_W-1:0] y;
    logic signed [COORD_W-1:0] z;
  } box_answer_t;

  logic clk;
  logic rst_n;
  logic start = 1'b0;
  logic busy;
  logic signed [COORD_W-1:0] in_point_x = '0;
  logic signed [COORD_W-1:0] in_point_y = '0;
  logic signed [COORD_W-1:0] in_point_z = '0;
  logic cfg_valid = 1'b0;
  logic cfg_ready;
  logic [obbpq_pkg::CFG_INDEX_W-1:0] cfg_index = '0;
  logic [obbpq_pkg::CFG_DATA_W-1:0] cfg_data = '0;
  logic out_valid;
  logic out_inside_res;
  logic signed [COORD_W-1:0] out_nearest_x;
  logic signed [COORD_W-1:0] out_nearest_y;
  logic signed [COORD_W-1:0] out_nearest_z;

  // Box registers as the block should hold them, reset values included.
  logic [obbpq_pkg::CENTER_REG_W-1:0] box_center = '0;
  logic [obbpq_pkg::HALF_REG_W-1:0] box_half = '0;
  logic [obbpq_pkg::BASIS_REG_W-1:0] box_axis [3] = '{
    48'd1 << FRAC_B,
    (48'd1 << FRAC_B) << AXIS_W,
    (48'd1 << FRAC_B) << (2 * AXIS_W)
  };

  query_point_t point_backlog[$];
  box_answer_t box_answers[$];
  box_answer_t front_answer;
  logic point_held = 1'b0;
  int points_taken = 0;
  int answers_seen = 0;
  int inside_seen = 0;
  int mismatches = 0;
  int reg_writes = 0;
  int box_settings = 0;

  obb_point_query_top #(
    .COORD_WIDTH(COORD_W),
    .BASIS_FRAC_BITS(FRAC_B)
  ) dut (
    .clk(clk),
    .rst_n(rst_n),
    .start(start),
    .busy(busy),
    .in_point_x(in_point_x),
    .in_point_y(in_point_y),
    .in_point_z(in_point_z),
    .cfg_valid(cfg_valid),
    .cfg_ready(cfg_ready),
    .cfg_index(cfg_index),
    .cfg_data(cfg_data),
    .out_valid(out_valid),
    .out_inside_res(out_inside_res),
    .out_nearest_x(out_nearest_x),
    .out_nearest_y(out_nearest_y),
    .out_nearest_z(out_nearest_z)
  );

  initial begin
    clk = 1'b0;
    forever #(CLK_PERIOD / 2) clk = ~clk;
  end

  function automatic longint clip_coord(longint v);
    if (v > COORD_MAX) return COORD_MAX;
    if (v < COORD_MIN) return COORD_MIN;
    return v;
  endfunction

  function automatic logic [63:0] pack_fields(longint f0, longint f1, longint f2, int w);
    logic [63:0] m;
    m = (64'd1 << w) - 64'd1;
    return (64'(f0) & m) | ((64'(f1) & m) << w) | ((64'(f2) & m) << (2 * w));
  endfunction

  // Project onto the three axes, test strictly inside, clamp and rebuild the nearest point.
  function automatic box_answer_t query_box(query_point_t pt);
    box_answer_t ans;
    longint cen[3];
    longint dlt[3];
    longint bas[3][3];
    longint clp[3];
    longint acc;
    longint h;
    longint v;
    int a;
    int m;
    ans.in_box = 1'b1;
    dlt[0] = longint'(pt.x);
    dlt[1] = longint'(pt.y);
    dlt[2] = longint'(pt.z);
    for (m = 0; m < 3; m++) begin
      cen[m] = longint'($signed(box_center[m*COORD_W +: COORD_W]));
      dlt[m] = dlt[m] - cen[m];
    end
    for (a = 0; a < 3; a++)
      for (m = 0; m < 3; m++)
        bas[a][m] = longint'($signed(box_axis[a][m*AXIS_W +: AXIS_W]));
    for (a = 0; a < 3; a++) begin
      acc = 0;
      for (m = 0; m < 3; m++) acc += dlt[m] * bas[a][m];
      h = longint'(box_half[a*HALF_W +: HALF_W]) << FRAC_B;
      if (acc >= h || acc <= -h) ans.in_box = 1'b0;
      if (acc > h) acc = h;
      if (acc < -h) acc = -h;
      clp[a] = acc;
    end
    for (m = 0; m < 3; m++) begin
      // round from Q.28 to an integer, ties toward plus infinity
      acc = longint'(1) << (2 * FRAC_B - 1);
      for (a = 0; a < 3; a++) acc += bas[a][m] * clp[a];
      v = clip_coord(cen[m] + (acc >>> (2 * FRAC_B)));
      if (m == 0) ans.x = v[COORD_W-1:0];
      else if (m == 1) ans.y = v[COORD_W-1:0];
      else ans.z = v[COORD_W-1:0];
    end
    return ans;
  endfunction

  function automatic void check_field(string label, longint want, longint got);
    if (want != got) begin
      mismatches++;
      $display("%0t ns: %s mismatch, expected %0d, actual %0d", $time, label, want, got);
    end
  endfunction

  // Input side: record each transfer and predict its answer.
  always @(posedge clk) begin
    point_held <= rst_n && start && busy;
    if (rst_n && start && !busy) begin
      box_answers.push_back(query_box(point_backlog.pop_front()));
      points_taken++;
    end
  end

  // Driver: random gaps, none in a stretch in the middle of the run.
  always @(negedge clk) begin
    if (!rst_n) begin
      start <= 1'b0;
    end else if (point_held) begin
      // hold the offered point until it is taken
    end else if (point_backlog.size() != 0 &&
                 ((points_taken >= 600 && points_taken < 950) || $urandom_range(99) >= 16)) begin
      start <= 1'b1;
      in_point_x <= point_backlog[0].x;
      in_point_y <= point_backlog[0].y;
      in_point_z <= point_backlog[0].z;
    end else begin
      start <= 1'b0;
    end
  end

  always @(posedge clk) begin
    if (rst_n && out_valid) begin
      answers_seen++;
      if (box_answers.size() == 0) begin
        mismatches++;
        $display("%0t ns: unexpected result, inside %0d nearest (%0d, %0d, %0d)", $time,
                 out_inside_res, out_nearest_x, out_nearest_y, out_nearest_z);
      end else begin
        front_answer = box_answers.pop_front();
        check_field("inside_res", front_answer.in_box, out_inside_res);
        check_field("nearest_x", front_answer.x, out_nearest_x);
        check_field("nearest_y", front_answer.y, out_nearest_y);
        check_field("nearest_z", front_answer.z, out_nearest_z);
        if (out_inside_res) inside_seen++;
      end
    end
  end

  task automatic queue_point(longint x, longint y, longint z);
    query_point_t pt;
    pt.x = x[COORD_W-1:0];
    pt.y = y[COORD_W-1:0];
    pt.z = z[COORD_W-1:0];
    point_backlog.push_back(pt);
  endtask

  // Point scattered around the current box, reaching a bit past its extents.
  task automatic queue_near_point();
    longint span;
    longint h;
    longint c[3];
    int m;
    span = 0;
    for (m = 0; m < 3; m++) begin
      h = longint'(box_half[m*HALF_W +: HALF_W]);
      if (h > span) span = h;
    end
    span = span + span / 2 + 16;
    if (span > COORD_MAX) span = COORD_MAX;
    for (m = 0; m < 3; m++)
      c[m] = clip_coord(longint'($signed(box_center[m*COORD_W +: COORD_W])) +
                        longint'($urandom_range(0, int'(2 * span))) - span);
    queue_point(c[0], c[1], c[2]);
  endtask

  task automatic write_box_reg(logic [obbpq_pkg::CFG_INDEX_W-1:0] idx,
                               logic [obbpq_pkg::CFG_DATA_W-1:0] data);
    @(negedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= data;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    reg_writes++;
    case (idx)
      obbpq_pkg::CFG_CENTER:  box_center = data[obbpq_pkg::CENTER_REG_W-1:0];
      obbpq_pkg::CFG_HALF:    box_half = data[obbpq_pkg::HALF_REG_W-1:0];
      obbpq_pkg::CFG_BASIS_I: box_axis[0] = data[obbpq_pkg::BASIS_REG_W-1:0];
      obbpq_pkg::CFG_BASIS_J: box_axis[1] = data[obbpq_pkg::BASIS_REG_W-1:0];
      obbpq_pkg::CFG_BASIS_K: box_axis[2] = data[obbpq_pkg::BASIS_REG_W-1:0];
      default: ;  // no such register: drop
    endcase
  endtask

  task automatic release_cfg();
    @(negedge clk);
    cfg_valid <= 1'b0;
    box_settings++;
  endtask

  task automatic wait_drained();
    while (point_backlog.size() != 0 || box_answers.size() != 0) @(negedge clk);
    repeat (obbpq_pkg::PIPE_DEPTH) @(negedge clk);
  endtask

  // Proper rotation: about z, then about x; third axis is the cross product.
  task automatic set_rotated_box(int half_cap);
    real az;
    real ax;
    real cz;
    real sz;
    real cx;
    real sx;
    az = $urandom_range(0, 359) * 3.14159265358979 / 180.0;
    ax = $urandom_range(0, 359) * 3.14159265358979 / 180.0;
    cz = $cos(az);
    sz = $sin(az);
    cx = $cos(ax);
    sx = $sin(ax);
    write_box_reg(obbpq_pkg::CFG_CENTER,
                  pack_fields(longint'($urandom_range(0, 1 << 20)) - (1 << 19),
                              longint'($urandom_range(0, 1 << 20)) - (1 << 19),
                              longint'($urandom_range(0, 1 << 20)) - (1 << 19),
                              COORD_W));
    write_box_reg(obbpq_pkg::CFG_HALF,
                  pack_fields($urandom_range(0, half_cap), $urandom_range(0, half_cap),
                              $urandom_range(0, half_cap), HALF_W));
    write_box_reg(obbpq_pkg::CFG_BASIS_I,
                  pack_fields($rtoi(cz * 16384.0), $rtoi(sz * cx * 16384.0),
                              $rtoi(sz * sx * 16384.0), AXIS_W));
    write_box_reg(obbpq_pkg::CFG_BASIS_J,
                  pack_fields($rtoi(-sz * 16384.0), $rtoi(cz * cx * 16384.0),
                              $rtoi(cz * sx * 16384.0), AXIS_W));
    write_box_reg(obbpq_pkg::CFG_BASIS_K,
                  pack_fields(0, $rtoi(-sx * 16384.0), $rtoi(cx * 16384.0), AXIS_W));
  endtask

  function automatic logic [obbpq_pkg::CFG_DATA_W-1:0] extreme_reg(int w);
    case ($urandom_range(3))
      0: return '0;
      1: return '1;
      2: return pack_fields(longint'(1) << (w - 1), longint'(1) << (w - 1),
                            longint'(1) << (w - 1), w);
      default: return pack_fields((longint'(1) << (w - 1)) - 1, (longint'(1) << (w - 1)) - 1,
                                  (longint'(1) << (w - 1)) - 1, w);
    endcase
  endfunction

  initial begin
    int phase;
    int n;
    int idx;
    rst_n = 1'b0;
    repeat (10) @(negedge clk);
    rst_n <= 1'b1;

    // Reset box: zero extents, identity axes; every point is outside and maps to the centre.
    queue_point(0, 0, 0);
    queue_point(COORD_MAX, COORD_MAX, COORD_MAX);
    queue_point(COORD_MIN, COORD_MIN, COORD_MIN);
    queue_point(COORD_MAX, COORD_MIN, 0);
    queue_point(1, -1, COORD_MIN);
    wait_drained();

    // Axis-aligned box: inside, both faces exactly, clamping at the field extremes.
    write_box_reg(obbpq_pkg::CFG_CENTER, pack_fields(256, -512, 0, COORD_W));
    write_box_reg(obbpq_pkg::CFG_HALF, pack_fields(2560, 5120, 7680, HALF_W));
    write_box_reg(obbpq_pkg::CFG_BASIS_I, pack_fields(1 << FRAC_B, 0, 0, AXIS_W));
    write_box_reg(obbpq_pkg::CFG_BASIS_J, pack_fields(0, 1 << FRAC_B, 0, AXIS_W));
    write_box_reg(obbpq_pkg::CFG_BASIS_K, pack_fields(0, 0, 1 << FRAC_B, AXIS_W));
    release_cfg();
    queue_point(256, -512, 0);
    queue_point(256 + 2560, -512, 0);
    queue_point(256 + 2559, -512 + 5119, 7679);
    queue_point(256 - 2560, -512, 0);
    queue_point(COORD_MAX, COORD_MAX, COORD_MAX);
    queue_point(COORD_MIN, COORD_MIN, COORD_MIN);
    queue_point(300, -512 - 5121, 100);
    wait_drained();

    // Degenerate axes: half-length i, zero j, k at -2; writes past the last register.
    write_box_reg(obbpq_pkg::CFG_CENTER, '0);
    write_box_reg(obbpq_pkg::CFG_HALF, pack_fields(1 << 19, 1000, COORD_MAX, HALF_W));
    write_box_reg(obbpq_pkg::CFG_BASIS_I, pack_fields(1 << (FRAC_B - 1), 0, 0, AXIS_W));
    write_box_reg(obbpq_pkg::CFG_BASIS_J, '0);
    write_box_reg(obbpq_pkg::CFG_BASIS_K, pack_fields(0, 0, -(1 << (AXIS_W - 1)), AXIS_W));
    for (idx = obbpq_pkg::CFG_BASIS_K + 1; idx < (1 << obbpq_pkg::CFG_INDEX_W); idx++)
      write_box_reg(obbpq_pkg::CFG_INDEX_W'(idx), {$urandom, $urandom});
    release_cfg();
    queue_point(2, 0, 0);
    queue_point(-2, 0, 0);
    queue_point(6, 0, -2);
    queue_point(0, 0, COORD_MAX);
    queue_point(0, 0, COORD_MIN);
    queue_point(COORD_MAX, COORD_MIN, 1);
    wait_drained();

    for (phase = 0; phase < RANDOM_PHASES; phase++) begin
      case (phase % 4)
        0: set_rotated_box(1 << 16);
        1: begin
          for (idx = obbpq_pkg::CFG_CENTER; idx < (1 << obbpq_pkg::CFG_INDEX_W); idx++)
            write_box_reg(obbpq_pkg::CFG_INDEX_W'(idx), {$urandom, $urandom});
        end
        2: begin
          write_box_reg(obbpq_pkg::CFG_CENTER, extreme_reg(COORD_W));
          write_box_reg(obbpq_pkg::CFG_HALF, extreme_reg(HALF_W));
          write_box_reg(obbpq_pkg::CFG_BASIS_I, extreme_reg(AXIS_W));
          write_box_reg(obbpq_pkg::CFG_BASIS_J, extreme_reg(AXIS_W));
          write_box_reg(obbpq_pkg::CFG_BASIS_K, extreme_reg(AXIS_W));
        end
        default: set_rotated_box(64);
      endcase
      release_cfg();
      for (n = 0; n < PHASE_POINTS; n++) begin
        if ($urandom_range(99) < 70) queue_near_point();
        else queue_point(longint'($signed($urandom() & 32'h1FFFFF) << 11) >>> 11,
                         longint'($signed($urandom() & 32'h1FFFFF) << 11) >>> 11,
                         longint'($signed($urandom() & 32'h1FFFFF) << 11) >>> 11);
      end
      wait_drained();
    end

    n = 0;
    while (box_answers.size() != 0 && n < 1000) begin
      @(negedge clk);
      n++;
    end
    repeat (obbpq_pkg::PIPE_DEPTH + 3) @(negedge clk);
    if (box_answers.size() != 0) begin
      mismatches += box_answers.size();
      $display("%0t ns: %0d expected results never arrived", $time, box_answers.size());
    end
    $display("Checked %0d query results across %0d box settings and %0d register writes;",
             answers_seen, box_settings, reg_writes);
    $display("%0d of them strictly inside, %0d disagreements.", inside_seen, mismatches);
    if (mismatches == 0) begin
      $display("obb_point_query_top test passed");
    end else begin
      $display("obb_point_query_top test failed");
    end
    $finish;
  end

  initial begin
    #(CLK_PERIOD * 300000);
    $display("%0t ns: run did not finish in time", $time);
    $display("obb_point_query_top test failed");
    $finish;
  end

endmodule

/* files.f */
+incdir+src
src/obbpq_pkg.sv
src/obb_point_query_top.sv
src/obbpq_checker.sv
sim/tb_obb_point_query_top.sv
